// ===== design/jcpr_pkg.sv =====
// ----------------------------------------------------------------------------
// jcpr_pkg
// Shared types, command codes and port constants for the joypad command
// packet receiver.
// ----------------------------------------------------------------------------
package jcpr_pkg;

  localparam int PACKET_BYTES_DEF = 16;
  localparam int STORE_DEPTH      = 16;

  localparam logic [1:0] CMD_PORT_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ_BYTE  = 2'd1;
  localparam logic [1:0] CMD_READ_FLAG  = 2'd2;
  localparam logic [1:0] CMD_UNUSED     = 2'd3;

  localparam logic [7:0] PORT_PULSE = 8'h00;
  localparam logic [7:0] PORT_ONE   = 8'h10;
  localparam logic [7:0] PORT_ZERO  = 8'h20;
  localparam logic [7:0] PORT_HIGH  = 8'h30;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] port_value;
    logic [3:0] byte_index;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       packet_ready;
    logic [1:0] player_index;
  } result_t;

  typedef struct packed {
    logic       ready_flag;
    logic [1:0] player_mode;
  } status_t;

  // Wrap mask for the selected player: one, two or four players.
  function automatic logic [1:0] player_mask(input logic [1:0] mode);
    logic [1:0] m;
    unique case (mode)
      2'd0:    m = 2'b00;
      2'd1:    m = 2'b01;
      default: m = 2'b11;
    endcase
    return m;
  endfunction

endpackage

// ===== design/jcpr_core.sv =====
// ----------------------------------------------------------------------------
// jcpr_core
// Receiver state, packet store and the per-beat update logic.
// ----------------------------------------------------------------------------
module jcpr_core #(
  parameter int PACKET_BYTES = jcpr_pkg::PACKET_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  jcpr_pkg::item_t   item,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_mode,
  output jcpr_pkg::result_t result,
  output jcpr_pkg::status_t status
);
  import jcpr_pkg::*;

  localparam logic [4:0] PB = 5'(PACKET_BYTES);

  logic [7:0] last_port_r, last_port_nxt;
  logic       wait_high_r, wait_high_nxt;
  logic       listening_r, listening_nxt;
  logic       ready_r, ready_nxt;
  logic [4:0] byte_cnt_r, byte_cnt_nxt;
  logic [2:0] bit_cnt_r, bit_cnt_nxt;
  logic [1:0] player_r, player_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic [7:0] store_r [STORE_DEPTH];

  logic       wr_en;
  logic       wr_bit;
  logic [7:0] rd_data;
  logic       adv;

  always_comb begin
    last_port_nxt = last_port_r;
    wait_high_nxt = wait_high_r;
    listening_nxt = listening_r;
    ready_nxt     = ready_r;
    byte_cnt_nxt  = byte_cnt_r;
    bit_cnt_nxt   = bit_cnt_r;
    player_nxt    = player_r;
    mode_nxt      = mode_r;
    wr_en         = 1'b0;
    wr_bit        = 1'b0;
    rd_data       = 8'd0;
    adv           = 1'b0;
    if (step_en) begin
      unique case (item.cmd)
        CMD_PORT_WRITE: begin
          if (item.port_value != last_port_r) begin
            last_port_nxt = item.port_value;
            if (item.port_value == PORT_PULSE) begin
              wait_high_nxt = 1'b1;
              byte_cnt_nxt  = 5'd0;
              bit_cnt_nxt   = 3'd0;
            end else if (wait_high_r) begin
              if (item.port_value == PORT_ONE || item.port_value == PORT_ZERO) begin
                wait_high_nxt = 1'b0;
                listening_nxt = 1'b0;
              end else if (item.port_value == PORT_HIGH) begin
                wait_high_nxt = 1'b0;
                listening_nxt = 1'b1;
              end
            end else if (listening_r) begin
              if (item.port_value == PORT_ZERO) begin
                if (byte_cnt_r >= PB && bit_cnt_r == 3'd0) begin
                  ready_nxt     = 1'b1;
                  listening_nxt = 1'b0;
                end else if (byte_cnt_r < PB) begin
                  wr_en  = 1'b1;
                  wr_bit = 1'b0;
                end
                adv = 1'b1;
              end else if (item.port_value == PORT_ONE) begin
                if (byte_cnt_r >= PB) begin
                  listening_nxt = 1'b0;
                end else begin
                  wr_en  = 1'b1;
                  wr_bit = 1'b1;
                  adv    = 1'b1;
                end
              end
              wait_high_nxt = listening_nxt;
            end else if (!last_port_r[5] && item.port_value[5]) begin
              player_nxt = (player_r + 2'd1) & player_mask(mode_r);
            end
          end
        end
        CMD_READ_BYTE: begin
          ready_nxt = 1'b0;
          rd_data   = store_r[item.byte_index];
        end
        CMD_READ_FLAG: begin
          rd_data = {7'd0, ready_r};
        end
        CMD_UNUSED: begin
          rd_data = 8'd0;
        end
        default: rd_data = 8'd0;
      endcase
      if (adv) begin
        bit_cnt_nxt = bit_cnt_r + 3'd1;
        if (bit_cnt_r == 3'd7) begin
          byte_cnt_nxt = byte_cnt_r + 5'd1;
        end
      end
    end
    if (cfg_we) begin
      mode_nxt   = cfg_mode;
      player_nxt = player_nxt & player_mask(cfg_mode);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_port_r <= 8'd0;
      wait_high_r <= 1'b1;
      listening_r <= 1'b0;
      ready_r     <= 1'b0;
      byte_cnt_r  <= 5'd0;
      bit_cnt_r   <= 3'd0;
      player_r    <= 2'd0;
      mode_r      <= 2'd0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_r[i] <= 8'd0;
      end
    end else begin
      last_port_r <= last_port_nxt;
      wait_high_r <= wait_high_nxt;
      listening_r <= listening_nxt;
      ready_r     <= ready_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      player_r    <= player_nxt;
      mode_r      <= mode_nxt;
      if (wr_en) begin
        store_r[byte_cnt_r[3:0]][bit_cnt_r] <= wr_bit;
      end
    end
  end

  assign result.read_data    = rd_data;
  assign result.packet_ready = ready_nxt;
  assign result.player_index = player_nxt;
  assign status.ready_flag   = ready_r;
  assign status.player_mode  = mode_r;

endmodule

// ===== design/joypad_command_packet_receiver.sv =====
// ----------------------------------------------------------------------------
// joypad_command_packet_receiver
// Stream-attached receiver for joypad-pulse command packets.
// ----------------------------------------------------------------------------
// Each input beat is a port write, a packet byte read, a ready flag read or an
// unused command and gives exactly one result beat. A beat is held in an input
// register, updates the receiver state and lands in an output register, so one
// beat per cycle is sustained while out_tready stays high and out_tvalid rises
// once the beat has passed both registers; the state update sets that rate.
// Write player_mode only while no beat is in flight.
module joypad_command_packet_receiver #(
  parameter int PACKET_BYTES = jcpr_pkg::PACKET_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // port_value[7:0], byte_index[11:8], zero pad
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // read_data[7:0], packet_ready[8],
                                  // player_index[10:9], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data    // player_mode
);
  import jcpr_pkg::*;

  logic    in_valid_r;
  item_t   item_r;
  logic    out_valid_r;
  result_t res_r;
  result_t res;
  status_t status;
  logic    step;
  logic    cfg_we;

  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.cmd        <= in_tuser;
      item_r.port_value <= in_tdata[7:0];
      item_r.byte_index <= in_tdata[11:8];
    end
    if (step) begin
      res_r <= res;
    end
  end

  jcpr_core #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step),
    .item     (item_r),
    .cfg_we   (cfg_we),
    .cfg_mode (cfg_data),
    .result   (res),
    .status   (status)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r.player_index, res_r.packet_ready, res_r.read_data};

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !out_valid_r |=> out_valid_r)
    else $error("held beat did not advance to the output register");

  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && item_r.cmd == CMD_READ_BYTE |=> !status.ready_flag)
    else $error("packet byte read left the ready flag set");

  a_player_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> (res.player_index & ~player_mask(status.player_mode)) == 2'b00)
    else $error("selected player beyond player count");

endmodule
